// File: rtl/jacobi_eigen_solver_assert.svh
// Assertion macros for the Jacobi eigen-solver.
`ifndef JACOBI_EIGEN_SOLVER_ASSERT_SVH
`define JACOBI_EIGEN_SOLVER_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define JES_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define JES_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/jes_pkg.sv
// ----------------------------------------------------------------------------
// Jacobi eigen-solver package
// Shared constants, types and fixed-point helpers.
// ----------------------------------------------------------------------------
package jes_pkg;

    localparam int MaxOrder = 4;
    localparam int IdxW     = 2;
    localparam int AddrW    = 4;
    localparam int CordicSteps = 16;

    localparam logic [1:0] OP_WR_D  = 2'd0;
    localparam logic [1:0] OP_WR_V  = 2'd1;
    localparam logic [1:0] OP_START = 2'd2;

    localparam logic [1:0] CFG_SIZE   = 2'd0;
    localparam logic [1:0] CFG_SWEEPS = 2'd1;

    localparam logic signed [63:0] QPi      = 64'sd205887;
    localparam logic signed [63:0] QHalfPi  = 64'sd102944;
    localparam logic signed [63:0] CordicGain = 64'sd652032874;
    localparam logic signed [63:0] NormLimit = 64'sd1 <<< 40;

    function automatic logic signed [63:0] atan_tab(input logic [3:0] i);
        logic signed [63:0] r;
        case (i)
            4'd0:  r = 64'sd51472;
            4'd1:  r = 64'sd30386;
            4'd2:  r = 64'sd16055;
            4'd3:  r = 64'sd8150;
            4'd4:  r = 64'sd4091;
            4'd5:  r = 64'sd2047;
            4'd6:  r = 64'sd1024;
            4'd7:  r = 64'sd512;
            4'd8:  r = 64'sd256;
            4'd9:  r = 64'sd128;
            4'd10: r = 64'sd64;
            4'd11: r = 64'sd32;
            4'd12: r = 64'sd16;
            4'd13: r = 64'sd8;
            4'd14: r = 64'sd4;
            default: r = 64'sd2;
        endcase
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [64:0] x);
        logic signed [31:0] r;
        if (x > 65'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (x < -65'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

    // Arithmetic-unit operations.
    typedef enum logic [1:0] {
        ALU_ADD = 2'd0,
        ALU_SUB = 2'd1,
        ALU_MUL = 2'd2
    } t_alu_op;

    typedef struct packed {
        t_alu_op            op;
        logic signed [31:0] a;
        logic signed [31:0] b;
    } t_alu_req;

    typedef struct packed {
        logic               start;
        logic signed [63:0] y;
        logic signed [63:0] x;
    } t_cordic_req;

    typedef struct packed {
        logic               done;
        logic signed [31:0] c;
        logic signed [31:0] s;
    } t_cordic_rsp;

endpackage

// File: rtl/jes_alu.sv
// ----------------------------------------------------------------------------
// Jacobi eigen-solver arithmetic unit
// Registered saturating Q16.16 add, subtract and multiply.
// ----------------------------------------------------------------------------
module jes_alu (
    input  logic                    i_clk,
    input  jes_pkg::t_alu_req       i_req,
    output logic signed [31:0]      o_res
);

    logic signed [63:0] w_prod;
    logic signed [31:0] n_res;
    logic signed [31:0] r_res;

    assign w_prod = 64'(i_req.a) * 64'(i_req.b);

    always_comb begin
        case (i_req.op)
            jes_pkg::ALU_ADD: n_res = jes_pkg::sat32(65'(i_req.a) + 65'(i_req.b));
            jes_pkg::ALU_SUB: n_res = jes_pkg::sat32(65'(i_req.a) - 65'(i_req.b));
            jes_pkg::ALU_MUL: n_res = jes_pkg::sat32(65'(w_prod >>> 16));
            default:          n_res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_res = r_res;

endmodule

// File: rtl/jes_cordic.sv
// ----------------------------------------------------------------------------
// Jacobi eigen-solver CORDIC
// Iterative atan2 (vectoring) then cos/sin (rotation), one step per cycle.
// ----------------------------------------------------------------------------
module jes_cordic (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  jes_pkg::t_cordic_req    i_req,
    output jes_pkg::t_cordic_rsp    o_rsp
);

    typedef enum logic [4:0] {
        C_IDLE = 5'b00001,
        C_NORM = 5'b00010,
        C_VEC  = 5'b00100,
        C_ROT  = 5'b01000,
        C_DONE = 5'b10000
    } t_cstate;

    t_cstate r_state, n_state;
    logic signed [63:0] r_x, r_y, r_z, n_x, n_y, n_z;
    logic [3:0] r_i, n_i;
    logic signed [63:0] w_dx, w_dy, w_ax, w_ay, w_cr, w_sr;

    assign w_dx = r_y >>> r_i;
    assign w_dy = r_x >>> r_i;
    assign w_ax = r_x[63] ? -r_x : r_x;
    assign w_ay = r_y[63] ? -r_y : r_y;
    assign w_cr = (r_x + 64'sd8192) >>> 14;
    assign w_sr = (r_y + 64'sd8192) >>> 14;

    always_comb begin
        n_state = r_state;
        n_x = r_x;
        n_y = r_y;
        n_z = r_z;
        n_i = r_i;
        case (r_state)
            C_IDLE: begin
                if (i_req.start) begin
                    n_x = i_req.x;
                    n_y = i_req.y;
                    n_i = '0;
                    if (i_req.y == 64'sd0) begin
                        n_z = i_req.x[63] ? jes_pkg::QPi : 64'sd0;
                        n_x = jes_pkg::CordicGain;
                        n_y = '0;
                        n_state = C_ROT;
                        n_z = n_z >>> 1;
                    end else begin
                        n_z = '0;
                        n_state = C_NORM;
                    end
                end
            end
            C_NORM: begin
                if (w_ax < jes_pkg::NormLimit && w_ay < jes_pkg::NormLimit) begin
                    n_x = r_x <<< 1;
                    n_y = r_y <<< 1;
                end else begin
                    if (r_x[63]) begin
                        if (!r_y[63]) begin
                            n_x = r_y;
                            n_y = -r_x;
                            n_z = jes_pkg::QHalfPi;
                        end else begin
                            n_x = -r_y;
                            n_y = r_x;
                            n_z = -jes_pkg::QHalfPi;
                        end
                    end
                    n_state = C_VEC;
                end
            end
            C_VEC: begin
                if (!r_y[63]) begin
                    n_x = r_x + w_dx;
                    n_y = r_y - w_dy;
                    n_z = r_z + jes_pkg::atan_tab(r_i);
                end else begin
                    n_x = r_x - w_dx;
                    n_y = r_y + w_dy;
                    n_z = r_z - jes_pkg::atan_tab(r_i);
                end
                n_i = r_i + 4'd1;
                if (r_i == 4'(jes_pkg::CordicSteps - 1)) begin
                    n_z = n_z >>> 1;
                    n_x = jes_pkg::CordicGain;
                    n_y = '0;
                    n_state = C_ROT;
                end
            end
            C_ROT: begin
                if (!r_z[63]) begin
                    n_x = r_x - w_dx;
                    n_y = r_y + w_dy;
                    n_z = r_z - jes_pkg::atan_tab(r_i);
                end else begin
                    n_x = r_x + w_dx;
                    n_y = r_y - w_dy;
                    n_z = r_z + jes_pkg::atan_tab(r_i);
                end
                n_i = r_i + 4'd1;
                if (r_i == 4'(jes_pkg::CordicSteps - 1)) begin
                    n_state = C_DONE;
                end
            end
            C_DONE: n_state = C_IDLE;
            default: n_state = C_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_x <= n_x;
        r_y <= n_y;
        r_z <= n_z;
        r_i <= n_i;
    end

    assign o_rsp.done = (r_state == C_DONE);
    assign o_rsp.c = jes_pkg::sat32(65'(w_cr));
    assign o_rsp.s = jes_pkg::sat32(65'(w_sr));

endmodule

// File: rtl/jacobi_eigen_solver.sv
// ----------------------------------------------------------------------------
// Jacobi eigen-solver
// Cyclic Jacobi eigen-decomposition of a symmetric matrix of order 2 to 4.
// ----------------------------------------------------------------------------
// Usage: a command is taken when i_start is high and o_busy is low.
// Opcode 0 writes an entry of D, opcode 1 an entry of V; loads can follow
// back to back. Opcode 3 is ignored.
// Opcode 2 solves: sweeps of Givens rotations over all pairs p<q run until
// no diagonal entry changes or the sweep limit is reached. Each rotation runs
// the CORDIC unit (its run depends on whether Dpq is zero and on the
// normalization shifts) and then saturating multiply/add operations through
// one shared registered arithmetic unit, each issued and then captured.
// After the sweeps, the n*n entries of D and then of V stream out, one per
// cycle, each marked by o_valid for one cycle; the last one carries
// o_last_result. o_busy stays high through the sweeps and the stream and
// falls after the cycle of the last entry.
// The receiver cannot stall the stream. Configuration: i_cfg_valid/o_cfg_ready
// write matrix_size (index 0) and max_sweeps (index 1); o_cfg_ready is always
// high. Reset clears control state and restores the register defaults.
// ----------------------------------------------------------------------------
`include "jacobi_eigen_solver_assert.svh"

module jacobi_eigen_solver (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic [1:0]         i_opcode,
    input  logic [1:0]         i_row,
    input  logic [1:0]         i_col,
    input  logic signed [31:0] i_value,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [7:0]         i_cfg_data,
    output logic               o_valid,
    output logic               o_matrix_id,
    output logic [1:0]         o_out_row,
    output logic [1:0]         o_out_col,
    output logic signed [31:0] o_out_value,
    output logic               o_last_result
);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_SWEEP  = 11'b00000000010,
        S_RDPAIR = 11'b00000000100,
        S_CORDIC = 11'b00000001000,
        S_RDEL   = 11'b00000010000,
        S_OPS    = 11'b00000100000,
        S_WREL   = 11'b00001000000,
        S_DIAG   = 11'b00010000000,
        S_NEXT   = 11'b00100000000,
        S_EMIT   = 11'b01000000000,
        S_EMWAIT = 11'b10000000000
    } t_state;

    localparam logic [3:0] NumDiagOps = 4'd14;

    t_state r_state, n_state;
    logic signed [31:0] r_dmem [16];
    logic signed [31:0] r_vmem [16];
    logic [2:0] r_size;
    logic [7:0] r_max_sweeps;
    logic [7:0] r_sweep, n_sweep;
    logic r_changed, n_changed;
    logic [1:0] r_n;
    logic [1:0] r_p, r_q, r_i, n_p, n_q, n_i;
    logic r_phase, n_phase;          // 0: D element, 1: V element
    logic [3:0] r_op, n_op;
    logic r_wait, n_wait;
    logic signed [31:0] r_app, r_apq, r_aqq, r_c, r_s;
    logic signed [31:0] r_ep, r_eq, r_t0, r_t1, r_t2, r_cc, r_ss, r_sc2;
    logic signed [31:0] n_app, n_apq, n_aqq, n_c, n_s;
    logic signed [31:0] n_ep, n_eq, n_t0, n_t1, n_t2, n_cc, n_ss, n_sc2;
    logic [1:0] r_rd, n_rd;
    logic r_em_m, n_em_m;
    logic [1:0] r_er, r_ec, n_er, n_ec;
    logic r_ovalid;

    jes_pkg::t_alu_req    w_alu_req;
    logic signed [31:0]   w_alu_res;
    jes_pkg::t_cordic_req w_cor_req;
    jes_pkg::t_cordic_rsp w_cor_rsp;

    logic [3:0] w_pp, w_pq, w_qq, w_a1, w_a2, w_ea;
    logic w_we_d1, w_we_d2, w_we_v1, w_we_v2;
    logic [3:0] w_wa_d1, w_wa_d2, w_wa_v1, w_wa_v2;
    logic signed [31:0] w_wd_d1, w_wd_d2, w_wd_v1, w_wd_v2;
    logic [1:0] w_nm1;

    jes_alu u_alu (
        .i_clk (i_clk),
        .i_req (w_alu_req),
        .o_res (w_alu_res)
    );

    jes_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_cor_req),
        .o_rsp   (w_cor_rsp)
    );

    assign w_pp = {r_p, r_p};
    assign w_pq = {r_p, r_q};
    assign w_qq = {r_q, r_q};
    assign w_nm1 = r_n;
    assign w_ea = {r_er, r_ec};

    // Element addresses: D uses rows p,q at column i; V uses column p,q at row i.
    assign w_a1 = r_phase ? {r_i, r_p} : {r_p, r_i};
    assign w_a2 = r_phase ? {r_i, r_q} : {r_q, r_i};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= 3'd4;
            r_max_sweeps <= 8'd100;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                jes_pkg::CFG_SIZE:   r_size <= i_cfg_data[2:0];
                jes_pkg::CFG_SWEEPS: r_max_sweeps <= i_cfg_data;
                default: ;
            endcase
        end
    end
    assign o_cfg_ready = 1'b1;

    // Rotation and diagonal-update operation sequences on the shared unit.
    always_comb begin
        w_alu_req.op = jes_pkg::ALU_MUL;
        w_alu_req.a = r_c;
        w_alu_req.b = r_ep;
        if (r_state == S_OPS) begin
            case (r_op)
                4'd0: begin w_alu_req.a = r_c; w_alu_req.b = r_ep; end
                4'd1: begin w_alu_req.a = r_s; w_alu_req.b = r_eq; end
                4'd2: begin w_alu_req.op = jes_pkg::ALU_SUB;
                            w_alu_req.a = r_t0; w_alu_req.b = r_t1; end
                4'd3: begin w_alu_req.a = r_s; w_alu_req.b = r_ep; end
                4'd4: begin w_alu_req.a = r_c; w_alu_req.b = r_eq; end
                default: begin w_alu_req.op = jes_pkg::ALU_ADD;
                            w_alu_req.a = r_t1; w_alu_req.b = r_t0; end
            endcase
        end else begin
            case (r_op)
                4'd0: begin w_alu_req.a = r_c; w_alu_req.b = r_c; end
                4'd1: begin w_alu_req.a = r_s; w_alu_req.b = r_s; end
                4'd2: begin w_alu_req.a = r_s; w_alu_req.b = r_c; end
                4'd3: begin w_alu_req.op = jes_pkg::ALU_ADD;
                            w_alu_req.a = r_t0; w_alu_req.b = r_t0; end
                4'd4: begin w_alu_req.a = r_cc; w_alu_req.b = r_app; end
                4'd5: begin w_alu_req.a = r_sc2; w_alu_req.b = r_apq; end
                4'd6: begin w_alu_req.op = jes_pkg::ALU_SUB;
                            w_alu_req.a = r_t0; w_alu_req.b = r_t1; end
                4'd7: begin w_alu_req.a = r_ss; w_alu_req.b = r_aqq; end
                4'd8: begin w_alu_req.op = jes_pkg::ALU_ADD;
                            w_alu_req.a = r_t2; w_alu_req.b = r_t0; end
                4'd9: begin w_alu_req.a = r_ss; w_alu_req.b = r_app; end
                4'd10: begin w_alu_req.a = r_sc2; w_alu_req.b = r_apq; end
                4'd11: begin w_alu_req.op = jes_pkg::ALU_ADD;
                            w_alu_req.a = r_t0; w_alu_req.b = r_t1; end
                4'd12: begin w_alu_req.a = r_cc; w_alu_req.b = r_aqq; end
                default: begin w_alu_req.op = jes_pkg::ALU_ADD;
                            w_alu_req.a = r_t0; w_alu_req.b = r_t1; end
            endcase
        end
    end

    assign w_cor_req.start = (r_state == S_RDPAIR) && (r_rd == 2'd3);
    assign w_cor_req.y = 64'(r_apq) <<< 1;
    assign w_cor_req.x = 64'(r_aqq) - 64'(r_app);

    always_comb begin
        n_state = r_state;
        n_sweep = r_sweep;
        n_changed = r_changed;
        n_p = r_p; n_q = r_q; n_i = r_i;
        n_phase = r_phase;
        n_op = r_op;
        n_wait = r_wait;
        n_app = r_app; n_apq = r_apq; n_aqq = r_aqq;
        n_c = r_c; n_s = r_s;
        n_ep = r_ep; n_eq = r_eq;
        n_t0 = r_t0; n_t1 = r_t1; n_t2 = r_t2;
        n_cc = r_cc; n_ss = r_ss; n_sc2 = r_sc2;
        n_rd = r_rd;
        n_em_m = r_em_m; n_er = r_er; n_ec = r_ec;
        w_we_d1 = 1'b0; w_we_d2 = 1'b0; w_we_v1 = 1'b0; w_we_v2 = 1'b0;
        w_wa_d1 = w_a1; w_wa_d2 = w_a2; w_wa_v1 = w_a1; w_wa_v2 = w_a2;
        w_wd_d1 = r_t2; w_wd_d2 = r_t0; w_wd_v1 = r_t2; w_wd_v2 = r_t0;
        case (r_state)
            S_IDLE: begin
                if (i_start && i_opcode == jes_pkg::OP_START) begin
                    n_sweep = '0;
                    n_changed = 1'b1;
                    n_state = S_SWEEP;
                end
            end
            S_SWEEP: begin
                if (r_changed && r_sweep < r_max_sweeps) begin
                    n_sweep = r_sweep + 8'd1;
                    n_changed = 1'b0;
                    n_p = 2'd0;
                    n_q = 2'd1;
                    n_rd = 2'd0;
                    n_state = S_RDPAIR;
                end else begin
                    n_em_m = 1'b0; n_er = '0; n_ec = '0;
                    n_state = S_EMIT;
                end
            end
            S_RDPAIR: begin
                n_app = r_dmem[w_pp];
                n_apq = r_dmem[w_pq];
                n_aqq = r_dmem[w_qq];
                n_rd = r_rd + 2'd1;
                if (r_rd == 2'd3) begin
                    n_state = S_CORDIC;
                end
            end
            S_CORDIC: begin
                if (w_cor_rsp.done) begin
                    n_c = w_cor_rsp.c;
                    n_s = w_cor_rsp.s;
                    n_i = 2'd0;
                    n_phase = 1'b0;
                    n_state = S_RDEL;
                end
            end
            S_RDEL: begin
                if (!r_phase && (r_i == r_p || r_i == r_q)) begin
                    n_phase = 1'b1;
                end else begin
                    n_ep = r_phase ? r_vmem[w_a1] : r_dmem[w_a1];
                    n_eq = r_phase ? r_vmem[w_a2] : r_dmem[w_a2];
                    n_op = '0;
                    n_wait = 1'b0;
                    n_state = S_OPS;
                end
            end
            S_OPS: begin
                // Issue an operation, then capture its result in the next cycle.
                if (!r_wait) begin
                    n_wait = 1'b1;
                end else begin
                    n_wait = 1'b0;
                    n_op = r_op + 4'd1;
                    case (r_op)
                        4'd0: n_t0 = w_alu_res;
                        4'd1: n_t1 = w_alu_res;
                        4'd2: n_t2 = w_alu_res;
                        4'd3: n_t0 = w_alu_res;
                        4'd4: n_t1 = w_alu_res;
                        default: begin
                            n_t0 = w_alu_res;
                            n_state = S_WREL;
                        end
                    endcase
                end
            end
            S_WREL: begin
                if (!r_phase) begin
                    w_we_d1 = 1'b1; w_wa_d1 = {r_p, r_i};
                    w_we_d2 = 1'b1; w_wa_d2 = {r_q, r_i};
                    n_phase = 1'b1;
                    n_state = S_RDEL;
                end else begin
                    w_we_v1 = 1'b1;
                    w_we_v2 = 1'b1;
                    n_phase = 1'b0;
                    n_i = r_i + 2'd1;
                    if (r_i == w_nm1) begin
                        n_op = '0;
                        n_wait = 1'b0;
                        n_state = S_DIAG;
                    end else begin
                        n_state = S_RDEL;
                    end
                end
            end
            S_DIAG: begin
                if (!r_wait) begin
                    n_wait = 1'b1;
                end else begin
                    n_wait = 1'b0;
                    n_op = r_op + 4'd1;
                    case (r_op)
                        4'd0: n_cc = w_alu_res;
                        4'd1: n_ss = w_alu_res;
                        4'd2: n_t0 = w_alu_res;
                        4'd3: n_sc2 = w_alu_res;
                        4'd4: n_t0 = w_alu_res;
                        4'd5: n_t1 = w_alu_res;
                        4'd6: n_t2 = w_alu_res;
                        4'd7: n_t0 = w_alu_res;
                        4'd8: n_t2 = w_alu_res;
                        4'd9: n_t0 = w_alu_res;
                        4'd10: n_t1 = w_alu_res;
                        4'd11: n_t0 = w_alu_res;
                        4'd12: n_t1 = w_alu_res;
                        default: begin
                            // r_t2 holds new pp, result holds new qq.
                            n_state = S_NEXT;
                            w_we_d1 = 1'b1; w_wa_d1 = w_pq; w_wd_d1 = '0;
                            w_we_d2 = 1'b1; w_wa_d2 = {r_q, r_p}; w_wd_d2 = '0;
                            if (r_t2 != r_app) begin
                                w_we_v1 = 1'b0;
                                n_changed = 1'b1;
                            end
                            if (w_alu_res != r_aqq) begin
                                n_changed = 1'b1;
                            end
                            n_t0 = w_alu_res;
                        end
                    endcase
                    if (r_op == NumDiagOps - 4'd1) begin
                        n_state = S_NEXT;
                    end
                end
            end
            S_NEXT: begin
                // Commit diagonals, then advance the pair.
                w_we_d1 = (r_t2 != r_app); w_wa_d1 = w_pp; w_wd_d1 = r_t2;
                w_we_d2 = (r_t0 != r_aqq); w_wa_d2 = w_qq; w_wd_d2 = r_t0;
                n_rd = 2'd0;
                if (r_q == w_nm1) begin
                    if (r_p + 2'd1 == w_nm1) begin
                        n_state = S_SWEEP;
                    end else begin
                        n_p = r_p + 2'd1;
                        n_q = r_p + 2'd2;
                        n_state = S_RDPAIR;
                    end
                end else begin
                    n_q = r_q + 2'd1;
                    n_state = S_RDPAIR;
                end
            end
            S_EMIT: begin
                n_ec = r_ec + 2'd1;
                if (r_ec == w_nm1) begin
                    n_ec = '0;
                    n_er = r_er + 2'd1;
                    if (r_er == w_nm1) begin
                        n_er = '0;
                        n_em_m = 1'b1;
                        if (r_em_m) begin
                            n_state = S_EMWAIT;
                        end
                    end
                end
            end
            S_EMWAIT: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Order clamped to 2..4; r_n holds n-1.
    always_ff @(posedge i_clk) begin
        if (r_size < 3'd2) begin
            r_n <= 2'd1;
        end else if (r_size > 3'(jes_pkg::MaxOrder)) begin
            r_n <= 2'(jes_pkg::MaxOrder - 1);
        end else begin
            r_n <= 2'(r_size - 3'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sweep <= '0;
            r_changed <= 1'b1;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sweep <= n_sweep;
            r_changed <= n_changed;
            r_ovalid <= (r_state == S_EMIT);
        end
        r_p <= n_p; r_q <= n_q; r_i <= n_i;
        r_phase <= n_phase; r_op <= n_op; r_wait <= n_wait;
        r_app <= n_app; r_apq <= n_apq; r_aqq <= n_aqq;
        r_c <= n_c; r_s <= n_s; r_ep <= n_ep; r_eq <= n_eq;
        r_t0 <= n_t0; r_t1 <= n_t1; r_t2 <= n_t2;
        r_cc <= n_cc; r_ss <= n_ss; r_sc2 <= n_sc2;
        r_rd <= n_rd; r_em_m <= n_em_m; r_er <= n_er; r_ec <= n_ec;
        o_matrix_id <= r_em_m;
        o_out_row <= r_er;
        o_out_col <= r_ec;
        o_out_value <= r_em_m ? r_vmem[w_ea] : r_dmem[w_ea];
        o_last_result <= r_em_m && r_er == w_nm1 && r_ec == w_nm1;
    end

    // D memory: two write ports used by the rotation, plus the load and mirror writes.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start && i_opcode == jes_pkg::OP_WR_D) begin
            r_dmem[{i_row, i_col}] <= i_value;
        end
        if (w_we_d1) begin
            r_dmem[w_wa_d1] <= w_wd_d1;
        end
        if (w_we_d2) begin
            r_dmem[w_wa_d2] <= w_wd_d2;
        end
        // Symmetric mirror of the off-diagonal element writes.
        if (r_state == S_WREL && !r_phase) begin
            r_dmem[{r_i, r_p}] <= r_t2;
            r_dmem[{r_i, r_q}] <= r_t0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start && i_opcode == jes_pkg::OP_WR_V) begin
            r_vmem[{i_row, i_col}] <= i_value;
        end
        if (w_we_v1 && r_state == S_WREL) begin
            r_vmem[w_wa_v1] <= w_wd_v1;
        end
        if (w_we_v2 && r_state == S_WREL) begin
            r_vmem[w_wa_v2] <= w_wd_v2;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_valid = r_ovalid;

    `JES_ASSERT_IMP(a_valid_busy, i_clk, i_rst_n, o_valid, o_busy)
    `JES_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n,
        (i_start && !o_busy && i_opcode == jes_pkg::OP_START), o_busy)
    `JES_ASSERT_NEXT(a_last_idle, i_clk, i_rst_n, (o_valid && o_last_result), !o_valid)

endmodule

// File: test/jacobi_eigen_solver_tb.sv
// ----------------------------------------------------------------------------
// Jacobi eigen-solver testbench
// Loads D and V entries, runs solves under many size and sweep settings, and
// checks every streamed entry against a fixed-point model held in a scoreboard.
// ----------------------------------------------------------------------------
module jacobi_eigen_solver_tb;

    localparam logic [1:0] OpUnused     = 2'd3;
    localparam logic [1:0] CfgUnusedLo  = 2'd2;
    localparam logic [1:0] CfgUnusedHi  = 2'd3;
    localparam int         CycleLimit   = 4000000;
    localparam int         ItemTarget   = 270;
    localparam int         SettleCycles = 40;

    typedef struct {
        bit       id;
        bit [1:0] r;
        bit [1:0] c;
        int       val;
        bit       last;
    } t_entry;

    class t_eigen_scoreboard;
        int     dm[16];
        int     vm[16];
        int     order_reg = 4;
        int     sweep_limit = 100;
        t_entry pending[$];
        int     errors;
        int     matched;
        int     solves;

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        function void write_cfg(logic [1:0] idx, logic [7:0] data);
            if (idx == jes_pkg::CFG_SIZE) order_reg = data & 8'd7;
            else if (idx == jes_pkg::CFG_SWEEPS) sweep_limit = data;
        endfunction

        function int sat(longint x);
            if (x > 64'sd2147483647) return 32'sh7fffffff;
            if (x < -64'sd2147483648) return 32'sh80000000;
            return int'(x);
        endfunction

        function int qmul(int a, int b);
            return sat((longint'(a) * longint'(b)) >>> 16);
        endfunction

        function int qadd(int a, int b);
            return sat(longint'(a) + longint'(b));
        endfunction

        function int qsub(int a, int b);
            return sat(longint'(a) - longint'(b));
        endfunction

        function longint angle_of(longint y, longint x);
            longint z, t, dx, dy;
            longint lim;
            z = 0;
            lim = longint'(1) << 40;
            if (y == 0) return (x >= 0) ? 0 : 205887;
            while ((x < 0 ? -x : x) < lim && (y < 0 ? -y : y) < lim) begin
                x = x * 2;
                y = y * 2;
            end
            if (x < 0) begin
                t = x;
                if (y >= 0) begin
                    x = y; y = -t; z = 102944;
                end else begin
                    x = -y; y = t; z = -102944;
                end
            end
            for (int i = 0; i < 16; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (y >= 0) begin
                    x += dx; y -= dy; z += jes_pkg::atan_tab(4'(i));
                end else begin
                    x -= dx; y += dy; z -= jes_pkg::atan_tab(4'(i));
                end
            end
            return z;
        endfunction

        function void rotation(longint phi, output int c, output int s);
            longint x, y, z, dx, dy;
            x = 652032874;
            y = 0;
            z = phi;
            for (int i = 0; i < 16; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x -= dx; y += dy; z -= jes_pkg::atan_tab(4'(i));
                end else begin
                    x += dx; y -= dy; z += jes_pkg::atan_tab(4'(i));
                end
            end
            c = sat((x + 8192) >>> 14);
            s = sat((y + 8192) >>> 14);
        endfunction

        // One Givens rotation on pair (p,q); returns 1 when a diagonal entry moved.
        function bit rotate(int n, int p, int q);
            int app, apq, aqq, c, s, cc, ss, sc2, npp, nqq, a, b;
            bit moved;
            app = dm[p*4+p];
            apq = dm[p*4+q];
            aqq = dm[q*4+q];
            moved = 0;
            rotation(angle_of(2 * longint'(apq), longint'(aqq) - longint'(app)) >>> 1, c, s);
            for (int i = 0; i < n; i++) begin
                if (i != p && i != q) begin
                    a = dm[p*4+i];
                    b = dm[q*4+i];
                    dm[p*4+i] = qsub(qmul(c, a), qmul(s, b));
                    dm[i*4+p] = dm[p*4+i];
                    dm[q*4+i] = qadd(qmul(s, a), qmul(c, b));
                    dm[i*4+q] = dm[q*4+i];
                end
                a = vm[i*4+p];
                b = vm[i*4+q];
                vm[i*4+p] = qsub(qmul(c, a), qmul(s, b));
                vm[i*4+q] = qadd(qmul(s, a), qmul(c, b));
            end
            cc = qmul(c, c);
            ss = qmul(s, s);
            sc2 = qadd(qmul(s, c), qmul(s, c));
            npp = qadd(qsub(qmul(cc, app), qmul(sc2, apq)), qmul(ss, aqq));
            nqq = qadd(qadd(qmul(ss, app), qmul(sc2, apq)), qmul(cc, aqq));
            if (npp != app) begin
                dm[p*4+p] = npp; moved = 1;
            end
            if (nqq != aqq) begin
                dm[q*4+q] = nqq; moved = 1;
            end
            dm[p*4+q] = 0;
            dm[q*4+p] = 0;
            return moved;
        endfunction

        function void note_command(logic [1:0] op, logic [1:0] r, logic [1:0] c, int v);
            int n, sweeps;
            bit changed;
            t_entry e;
            if (op == jes_pkg::OP_WR_D) dm[r*4+c] = v;
            else if (op == jes_pkg::OP_WR_V) vm[r*4+c] = v;
            if (op != jes_pkg::OP_START) return;
            solves++;
            n = order_reg < 2 ? 2 :
                (order_reg > jes_pkg::MaxOrder ? jes_pkg::MaxOrder : order_reg);
            sweeps = 0;
            changed = 1;
            while (changed && sweeps < sweep_limit) begin
                sweeps++;
                changed = 0;
                for (int p = 0; p < n - 1; p++)
                    for (int q = p + 1; q < n; q++)
                        changed |= rotate(n, p, q);
            end
            for (int m = 0; m < 2; m++)
                for (int i = 0; i < n; i++)
                    for (int j = 0; j < n; j++) begin
                        e.id = m[0];
                        e.r = i[1:0];
                        e.c = j[1:0];
                        e.val = m == 0 ? dm[i*4+j] : vm[i*4+j];
                        e.last = (m == 1 && i == n - 1 && j == n - 1);
                        pending.push_back(e);
                    end
        endfunction

        task check_entry(t_entry got);
            t_entry w;
            if (pending.size() == 0) begin
                report($sformatf("unexpected entry id=%0d (%0d,%0d)", got.id, got.r, got.c));
                return;
            end
            w = pending.pop_front();
            matched++;
            if (got.id != w.id || got.r != w.r || got.c != w.c || got.last != w.last)
                report($sformatf("position got id=%0d (%0d,%0d) last=%0d, want id=%0d (%0d,%0d) last=%0d",
                                 got.id, got.r, got.c, got.last, w.id, w.r, w.c, w.last));
            if (got.val != w.val)
                report($sformatf("value at id=%0d (%0d,%0d) got %h want %h",
                                 w.id, w.r, w.c, got.val, w.val));
        endtask
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_start;
    logic               o_busy;
    logic [1:0]         i_opcode;
    logic [1:0]         i_row;
    logic [1:0]         i_col;
    logic signed [31:0] i_value;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index;
    logic [7:0]         i_cfg_data;
    logic               o_valid;
    logic               o_matrix_id;
    logic [1:0]         o_out_row;
    logic [1:0]         o_out_col;
    logic signed [31:0] o_out_value;
    logic               o_last_result;

    t_eigen_scoreboard sb = new();
    int items;
    int cycles;

    jacobi_eigen_solver dut (.*);

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    always @(posedge i_clk) begin
        t_entry got;
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL jacobi_eigen_solver");
            $finish;
        end
        if (i_rst_n && o_valid) begin
            got.id = o_matrix_id;
            got.r = o_out_row;
            got.c = o_out_col;
            got.val = o_out_value;
            got.last = o_last_result;
            sb.check_entry(got);
        end
    end

    // Called at a rising edge; returns at the edge where the transfer happened.
    task send_cmd(logic [1:0] op, logic [1:0] r, logic [1:0] c, logic [31:0] v);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_opcode <= op;
        i_row <= r;
        i_col <= c;
        i_value <= v;
        do @(posedge i_clk); while (o_busy);
        sb.note_command(op, r, c, v);
        items++;
    endtask

    task drain;
        i_start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0 || o_busy) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task write_reg(logic [1:0] idx, logic [7:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_cfg(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function logic [31:0] pick_value();
        if ($urandom_range(0, 9) == 0) return $urandom();
        return $urandom_range(0, 1 << 20) - (1 << 19);
    endfunction

    // Loads the leading n-by-n block: symmetric D, V mostly the identity.
    task load_block(int n);
        logic [31:0] x;
        bit plain_v;
        plain_v = $urandom_range(0, 3) != 0;
        for (int i = 0; i < n; i++)
            for (int j = i; j < n; j++) begin
                x = pick_value();
                send_cmd(jes_pkg::OP_WR_D, 2'(i), 2'(j), x);
                if (j != i) send_cmd(jes_pkg::OP_WR_D, 2'(j), 2'(i), x);
                if ($urandom_range(0, 15) == 0)
                    send_cmd(OpUnused, 2'($urandom()), 2'($urandom()), $urandom());
            end
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++)
                send_cmd(jes_pkg::OP_WR_V, 2'(i), 2'(j),
                         plain_v ? (i == j ? 32'h0001_0000 : 32'h0) : pick_value());
    endtask

    initial begin
        int n, sw;
        i_rst_n <= 1'b0;
        i_start <= 1'b0;
        i_opcode <= jes_pkg::OP_WR_D;
        i_row <= 2'd0;
        i_col <= 2'd0;
        i_value <= 32'sd0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= jes_pkg::CFG_SIZE;
        i_cfg_data <= 8'd0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Order 2 with saturating extremes; zero sweep limit emits the load as is.
        write_reg(jes_pkg::CFG_SIZE, 8'd0);
        write_reg(jes_pkg::CFG_SWEEPS, 8'd0);
        send_cmd(jes_pkg::OP_WR_D, 2'd0, 2'd0, 32'h7fff_ffff);
        send_cmd(jes_pkg::OP_WR_D, 2'd1, 2'd1, 32'h8000_0000);
        send_cmd(jes_pkg::OP_WR_D, 2'd0, 2'd1, 32'hffff_ffff);
        send_cmd(jes_pkg::OP_WR_D, 2'd1, 2'd0, 32'hffff_ffff);
        send_cmd(jes_pkg::OP_WR_V, 2'd0, 2'd0, 32'h0001_0000);
        send_cmd(jes_pkg::OP_WR_V, 2'd0, 2'd1, 32'h0);
        send_cmd(jes_pkg::OP_WR_V, 2'd1, 2'd0, 32'h0);
        send_cmd(jes_pkg::OP_WR_V, 2'd1, 2'd1, 32'h0001_0000);
        send_cmd(OpUnused, 2'd3, 2'd3, 32'h5555_aaaa);
        send_cmd(jes_pkg::OP_START, 2'd0, 2'd0, 32'h0);
        drain();
        write_reg(jes_pkg::CFG_SWEEPS, 8'd3);
        write_reg(CfgUnusedLo, 8'hff);
        write_reg(CfgUnusedHi, 8'hff);
        send_cmd(jes_pkg::OP_START, 2'd3, 2'd3, 32'hffff_ffff);
        drain();
        // Already diagonal with the larger entry first: zero off-diagonal and
        // a negative difference give a half-turn angle, under a long sweep limit.
        write_reg(jes_pkg::CFG_SIZE, 8'd1);
        write_reg(jes_pkg::CFG_SWEEPS, 8'd255);
        send_cmd(jes_pkg::OP_WR_D, 2'd0, 2'd0, 32'h0002_0000);
        send_cmd(jes_pkg::OP_WR_D, 2'd0, 2'd1, 32'h0);
        send_cmd(jes_pkg::OP_WR_D, 2'd1, 2'd0, 32'h0);
        send_cmd(jes_pkg::OP_WR_D, 2'd1, 2'd1, 32'hfffe_0000);
        send_cmd(jes_pkg::OP_START, 2'd0, 2'd0, 32'h0);
        drain();

        // Order 7 acts as 4; the whole 4x4 store gets written first.
        write_reg(jes_pkg::CFG_SIZE, 8'd7);
        write_reg(jes_pkg::CFG_SWEEPS, 8'd6);
        load_block(4);
        send_cmd(jes_pkg::OP_START, 2'd0, 2'd0, 32'h0);
        drain();

        while (items < ItemTarget) begin
            n = $urandom_range(2, 4);
            sw = $urandom_range(0, 7) == 0 && n == 2 ? 255 : $urandom_range(1, 10);
            write_reg(jes_pkg::CFG_SIZE, 8'(n));
            write_reg(jes_pkg::CFG_SWEEPS, 8'(sw));
            repeat ($urandom_range(1, 3)) begin
                if (items < ItemTarget) begin
                    load_block(n);
                    if ($urandom_range(0, 3) == 0)
                        send_cmd(jes_pkg::OP_WR_D, 2'($urandom()), 2'($urandom()),
                                 pick_value());
                    send_cmd(jes_pkg::OP_START, 2'($urandom()), 2'($urandom()),
                             $urandom());
                    // Sometimes hold off until the whole stream has come back.
                    if ($urandom_range(0, 2) == 0) drain();
                end
            end
            drain();
        end
        drain();

        $display("covered %0d commands and %0d solves, %0d entries compared",
                 items, sb.solves, sb.matched);
        $display("orders 2 to 4, sweep limits 0 to 255, saturating loads and noise commands");
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("PASS jacobi_eigen_solver");
        end else begin
            $display("%0d mismatches, %0d entries never seen", sb.errors, sb.pending.size());
            $display("FAIL jacobi_eigen_solver");
        end
        $finish;
    end
endmodule
